// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file cal_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is low.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cal_pkg.sv -----
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types and constants of the calibrated sensor value pipeline.
// ----------------------------------------------------------------------------
package cal_pkg;

    localparam int CODE_BITS_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int RST_P1_CODE  = 0;
    localparam int RST_P1_VALUE = 1792;
    localparam int RST_P2_CODE  = 2720;
    localparam int RST_P2_VALUE = 1024;
    localparam int RST_P3_CODE  = 0;
    localparam int RST_P3_VALUE = 0;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_P1_CODE   = 3'd0,
        REG_P1_VALUE  = 3'd1,
        REG_P2_CODE   = 3'd2,
        REG_P2_VALUE  = 3'd3,
        REG_P3_CODE   = 3'd4,
        REG_P3_VALUE  = 3'd5,
        REG_USE_THIRD = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_COINCIDENT = 2'd1,
        STAT_SATURATED  = 2'd2
    } status_t;

    typedef struct packed {
        logic valid;
        logic err;
    } ctl_t;

endpackage

// ----- rtl/calibrated_sensor_value.sv -----
// ----------------------------------------------------------------------------
// calibrated_sensor_value
// Two-point line or three-point quadratic calibration of a converter code.
// ----------------------------------------------------------------------------
// channel   dir  transfer               payload
// s_axis    in   tvalid & tready        tdata: adc_code
// m_axis    out  tvalid & tready        tdata: reading, tuser: status
// cfg       in   cfg_we                 cfg_index, cfg_wdata
//
// One code enters per cycle while the output is not stalled; the divider
// resolves one quotient bit per stage.
// Reset clears all valid bits and loads the default calibration points.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module calibrated_sensor_value #(
    parameter int CODE_BITS  = cal_pkg::CODE_BITS_DEF,
    parameter int VALUE_BITS = cal_pkg::VALUE_BITS_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              s_axis_tvalid,
    output logic                                              s_axis_tready,
    // [CODE_BITS-1:0] adc_code
    input  logic [((CODE_BITS+7)/8)*8-1:0]                    s_axis_tdata,
    output logic                                              m_axis_tvalid,
    input  logic                                              m_axis_tready,
    // [VALUE_BITS-1:0] reading
    output logic [((VALUE_BITS+7)/8)*8-1:0]                   m_axis_tdata,
    // [1:0] status
    output logic [1:0]                                        m_axis_tuser,
    input  logic                                              cfg_we,
    input  logic [cal_pkg::CFG_INDEX_BITS-1:0]                cfg_index,
    input  logic [(VALUE_BITS>CODE_BITS ? VALUE_BITS : CODE_BITS)-1:0] cfg_wdata
);
    import cal_pkg::*;

    localparam int C   = CODE_BITS;
    localparam int V   = VALUE_BITS;
    localparam int KW  = V + C + 1;
    localparam int PW  = 2 * C + 2;
    localparam int DW  = 3 * C + 3;
    localparam int W   = 3 * C + V + 7;
    localparam int MDW = ((V + 7) / 8) * 8;

    logic signed [C-1:0] c1_reg, c2_reg, c3_reg;
    logic signed [V-1:0] v1_reg, v2_reg, v3_reg;
    logic                use3_reg;

    logic                en;
    ctl_t                f_ctl, m_ctl, d_ctl;
    logic signed [KW-1:0] k [3];
    logic signed [PW-1:0] p [3];
    logic signed [DW-1:0] den;
    logic                neg;
    logic [W-1:0]        num2, den2;
    logic [V-1:0]        reading;
    status_t             status;

    logic                out_valid_reg;
    logic [V-1:0]        reading_reg;
    status_t             status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg   <= C'(RST_P1_CODE);
            v1_reg   <= V'(RST_P1_VALUE);
            c2_reg   <= C'(RST_P2_CODE);
            v2_reg   <= V'(RST_P2_VALUE);
            c3_reg   <= C'(RST_P3_CODE);
            v3_reg   <= V'(RST_P3_VALUE);
            use3_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_P1_CODE:   c1_reg   <= cfg_wdata[C-1:0];
                REG_P1_VALUE:  v1_reg   <= cfg_wdata[V-1:0];
                REG_P2_CODE:   c2_reg   <= cfg_wdata[C-1:0];
                REG_P2_VALUE:  v2_reg   <= cfg_wdata[V-1:0];
                REG_P3_CODE:   c3_reg   <= cfg_wdata[C-1:0];
                REG_P3_VALUE:  v3_reg   <= cfg_wdata[V-1:0];
                REG_USE_THIRD: use3_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    cal_front #(
        .CODE_BITS  (C),
        .VALUE_BITS (V)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en_i    (en),
        .valid_i (s_axis_tvalid),
        .x_i     (s_axis_tdata[C-1:0]),
        .c1_i    (c1_reg),
        .c2_i    (c2_reg),
        .c3_i    (c3_reg),
        .v1_i    (v1_reg),
        .v2_i    (v2_reg),
        .v3_i    (v3_reg),
        .use3_i  (use3_reg),
        .ctl_o   (f_ctl),
        .k_o     (k),
        .p_o     (p),
        .den_o   (den)
    );

    cal_mac #(
        .CODE_BITS  (C),
        .VALUE_BITS (V)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en_i    (en),
        .ctl_i   (f_ctl),
        .k_i     (k),
        .p_i     (p),
        .den_i   (den),
        .ctl_o   (m_ctl),
        .neg_o   (neg),
        .num2_o  (num2),
        .den2_o  (den2)
    );

    cal_div #(
        .CODE_BITS  (C),
        .VALUE_BITS (V)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en_i      (en),
        .ctl_i     (m_ctl),
        .neg_i     (neg),
        .num2_i    (num2),
        .den2_i    (den2),
        .ctl_o     (d_ctl),
        .reading_o (reading),
        .status_o  (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= d_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            reading_reg <= reading;
            status_reg  <= status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = MDW'(reading_reg);
    assign m_axis_tuser  = status_reg;

endmodule

// ----- rtl/cal_front.sv -----
// ----------------------------------------------------------------------------
// cal_front
// Code differences, point weights and basis products (two stages).
// ----------------------------------------------------------------------------
module cal_front #(
    parameter int CODE_BITS  = cal_pkg::CODE_BITS_DEF,
    parameter int VALUE_BITS = cal_pkg::VALUE_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      en_i,
    input  logic                                      valid_i,
    input  logic signed [CODE_BITS-1:0]               x_i,
    input  logic signed [CODE_BITS-1:0]               c1_i,
    input  logic signed [CODE_BITS-1:0]               c2_i,
    input  logic signed [CODE_BITS-1:0]               c3_i,
    input  logic signed [VALUE_BITS-1:0]              v1_i,
    input  logic signed [VALUE_BITS-1:0]              v2_i,
    input  logic signed [VALUE_BITS-1:0]              v3_i,
    input  logic                                      use3_i,
    output cal_pkg::ctl_t                             ctl_o,
    output logic signed [VALUE_BITS+CODE_BITS:0]      k_o [3],
    output logic signed [2*CODE_BITS+1:0]             p_o [3],
    output logic signed [3*CODE_BITS+2:0]             den_o
);
    import cal_pkg::*;

    localparam int DXW = CODE_BITS + 1;
    localparam int KW  = VALUE_BITS + CODE_BITS + 1;
    localparam int PW  = 2 * CODE_BITS + 2;
    localparam int DW  = 3 * CODE_BITS + 3;

    logic signed [DXW-1:0] xe, c1e, c2e, c3e;
    logic signed [DXW-1:0] d12, d13, d23, d21;
    logic signed [DXW-1:0] dx_next [3];
    logic signed [KW-1:0]  kq [3];
    logic signed [KW-1:0]  v1x, v2x;
    logic signed [KW-1:0]  k_next [3];
    logic signed [PW-1:0]  dpart_next;
    ctl_t                  ctl1_next;

    ctl_t                  ctl1_reg;
    logic                  mode1_reg;
    logic signed [DXW-1:0] dx_reg [3];
    logic signed [KW-1:0]  k1_reg [3];
    logic signed [PW-1:0]  dpart_reg;
    logic signed [DXW-1:0] d23_reg, d21_reg;

    logic signed [PW-1:0]  pm [3];
    logic signed [PW-1:0]  pe [2];
    logic signed [PW-1:0]  p_next [3];
    logic signed [DW-1:0]  dq, dl, den_next;

    ctl_t                  ctl2_reg;
    logic signed [KW-1:0]  k2_reg [3];
    logic signed [PW-1:0]  p_reg [3];
    logic signed [DW-1:0]  den_reg;

    assign xe  = DXW'(x_i);
    assign c1e = DXW'(c1_i);
    assign c2e = DXW'(c2_i);
    assign c3e = DXW'(c3_i);
    assign d12 = c1e - c2e;
    assign d13 = c1e - c3e;
    assign d23 = c2e - c3e;
    assign d21 = c2e - c1e;

    assign dx_next[0] = xe - c1e;
    assign dx_next[1] = xe - c2e;
    assign dx_next[2] = xe - c3e;

    assign kq[0] = v1_i * d23;
    assign kq[1] = v2_i * d13;
    assign kq[2] = v3_i * d12;
    assign v1x   = KW'(v1_i);
    assign v2x   = KW'(v2_i);

    assign k_next[0] = use3_i ? kq[0] : v2x;
    assign k_next[1] = use3_i ? kq[1] : v1x;
    assign k_next[2] = use3_i ? kq[2] : '0;

    assign dpart_next = d12 * d13;

    assign ctl1_next.valid = valid_i;
    assign ctl1_next.err   = use3_i ? ((c1_i == c2_i) || (c1_i == c3_i) || (c2_i == c3_i))
                                    : (c1_i == c2_i);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else if (en_i) begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            mode1_reg <= use3_i;
            dx_reg    <= dx_next;
            k1_reg    <= k_next;
            dpart_reg <= dpart_next;
            d23_reg   <= d23;
            d21_reg   <= d21;
        end
    end

    assign pm[0] = dx_reg[1] * dx_reg[2];
    assign pm[1] = dx_reg[0] * dx_reg[2];
    assign pm[2] = dx_reg[0] * dx_reg[1];
    assign pe[0] = PW'(dx_reg[0]);
    assign pe[1] = PW'(dx_reg[1]);

    assign p_next[0] = mode1_reg ? pm[0] : pe[0];
    assign p_next[1] = mode1_reg ? pm[1] : pe[1];
    assign p_next[2] = mode1_reg ? pm[2] : '0;

    assign dq       = dpart_reg * d23_reg;
    assign dl       = DW'(d21_reg);
    assign den_next = mode1_reg ? dq : dl;

    always_ff @(posedge aclk) begin
        if (en_i) begin
            k2_reg  <= k1_reg;
            p_reg   <= p_next;
            den_reg <= den_next;
        end
    end

    assign ctl_o = ctl2_reg;
    assign k_o   = k2_reg;
    assign p_o   = p_reg;
    assign den_o = den_reg;

endmodule

// ----- rtl/cal_mac.sv -----
// ----------------------------------------------------------------------------
// cal_mac
// Weighted basis sum, magnitudes and rounding offset (five stages).
// ----------------------------------------------------------------------------
module cal_mac #(
    parameter int CODE_BITS  = cal_pkg::CODE_BITS_DEF,
    parameter int VALUE_BITS = cal_pkg::VALUE_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      en_i,
    input  cal_pkg::ctl_t                             ctl_i,
    input  logic signed [VALUE_BITS+CODE_BITS:0]      k_i [3],
    input  logic signed [2*CODE_BITS+1:0]             p_i [3],
    input  logic signed [3*CODE_BITS+2:0]             den_i,
    output cal_pkg::ctl_t                             ctl_o,
    output logic                                      neg_o,
    output logic [3*CODE_BITS+VALUE_BITS+6:0]         num2_o,
    output logic [3*CODE_BITS+VALUE_BITS+6:0]         den2_o
);
    import cal_pkg::*;

    localparam int KW = VALUE_BITS + CODE_BITS + 1;
    localparam int PW = 2 * CODE_BITS + 2;
    localparam int PH = CODE_BITS + 1;
    localparam int DW = 3 * CODE_BITS + 3;
    localparam int TW = KW + PW;
    localparam int NW = TW + 2;
    localparam int W  = NW + 2;

    logic signed [PH:0]      pl [3];
    logic signed [PH-1:0]    ph [3];
    logic signed [KW+PH:0]   lo_next [3];
    logic signed [KW+PH-1:0] hi_next [3];
    logic signed [KW+PH:0]   lo_reg [3];
    logic signed [KW+PH-1:0] hi_reg [3];
    logic signed [DW-1:0]    den3_reg, den4_reg, den5_reg;

    logic signed [TW-1:0]    hw [3];
    logic signed [TW-1:0]    lw [3];
    logic signed [TW-1:0]    t_next [3];
    logic signed [TW-1:0]    t_reg [3];

    logic signed [NW-1:0]    n_next, n_reg;

    logic [NW-1:0]           nm_next, nm_reg;
    logic [DW-1:0]           dm_next, dm_reg;
    logic                    neg_next, neg6_reg, neg7_reg;

    logic [W-1:0]            num2_next, den2_next, num2_reg, den2_reg;

    ctl_t                    ctl3_reg, ctl4_reg, ctl5_reg, ctl6_reg, ctl7_reg;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        assign pl[g]      = $signed({1'b0, p_i[g][PH-1:0]});
        assign ph[g]      = p_i[g][PW-1:PH];
        assign lo_next[g] = k_i[g] * pl[g];
        assign hi_next[g] = k_i[g] * ph[g];
        assign hw[g]      = TW'(hi_reg[g]);
        assign lw[g]      = TW'(lo_reg[g]);
        assign t_next[g]  = (hw[g] <<< PH) + lw[g];
    end

    assign n_next   = NW'(t_reg[0]) - NW'(t_reg[1]) + NW'(t_reg[2]);
    assign nm_next  = n_reg[NW-1] ? -n_reg : n_reg;
    assign dm_next  = den5_reg[DW-1] ? -den5_reg : den5_reg;
    assign neg_next = n_reg[NW-1] ^ den5_reg[DW-1];

    assign num2_next = (W'(nm_reg) << 1) + W'(dm_reg);
    assign den2_next = W'(dm_reg) << 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            ctl7_reg <= '0;
        end else if (en_i) begin
            ctl3_reg <= ctl_i;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
            ctl7_reg <= ctl6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            den3_reg <= den_i;
            t_reg    <= t_next;
            den4_reg <= den3_reg;
            n_reg    <= n_next;
            den5_reg <= den4_reg;
            nm_reg   <= nm_next;
            dm_reg   <= dm_next;
            neg6_reg <= neg_next;
            num2_reg <= num2_next;
            den2_reg <= den2_next;
            neg7_reg <= neg6_reg;
        end
    end

    assign ctl_o  = ctl7_reg;
    assign neg_o  = neg7_reg;
    assign num2_o = num2_reg;
    assign den2_o = den2_reg;

endmodule

// ----- rtl/cal_div.sv -----
// ----------------------------------------------------------------------------
// cal_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module cal_div #(
    parameter int CODE_BITS  = cal_pkg::CODE_BITS_DEF,
    parameter int VALUE_BITS = cal_pkg::VALUE_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      en_i,
    input  cal_pkg::ctl_t                             ctl_i,
    input  logic                                      neg_i,
    input  logic [3*CODE_BITS+VALUE_BITS+6:0]         num2_i,
    input  logic [3*CODE_BITS+VALUE_BITS+6:0]         den2_i,
    output cal_pkg::ctl_t                             ctl_o,
    output logic [VALUE_BITS-1:0]                     reading_o,
    output cal_pkg::status_t                          status_o
);
    import cal_pkg::*;

    localparam int V  = VALUE_BITS;
    localparam int W  = 3 * CODE_BITS + VALUE_BITS + 7;
    localparam int NS = V + 2;

    logic [W-1:0] r_reg   [NS];
    logic [W-1:0] dv_reg  [NS];
    logic [V:0]   q_reg   [NS];
    logic         neg_reg [NS];
    logic         big_reg [NS];
    ctl_t         ctl_reg [NS];

    logic         big_next;
    logic [V:0]   q;
    logic         big, neg, sat_pos, sat_neg;
    logic [V-1:0] negq;

    assign big_next = num2_i >= (den2_i << (V + 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg[0] <= '0;
        end else if (en_i) begin
            ctl_reg[0] <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            r_reg[0]   <= num2_i;
            dv_reg[0]  <= den2_i;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg_i;
            big_reg[0] <= big_next;
        end
    end

    for (genvar j = 0; j <= V; j++) begin : g_step
        localparam int B = V - j;
        logic [W-1:0] sd;
        logic         ge;
        logic [W-1:0] r_next;
        logic [V:0]   q_next;

        assign sd     = dv_reg[j] << B;
        assign ge     = r_reg[j] >= sd;
        assign r_next = ge ? r_reg[j] - sd : r_reg[j];

        always_comb begin
            q_next    = q_reg[j];
            q_next[B] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[j+1] <= '0;
            end else if (en_i) begin
                ctl_reg[j+1] <= ctl_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en_i) begin
                r_reg[j+1]   <= r_next;
                dv_reg[j+1]  <= dv_reg[j];
                q_reg[j+1]   <= q_next;
                neg_reg[j+1] <= neg_reg[j];
                big_reg[j+1] <= big_reg[j];
            end
        end
    end

    assign q       = q_reg[NS-1];
    assign big     = big_reg[NS-1];
    assign neg     = neg_reg[NS-1];
    assign sat_pos = big | q[V] | q[V-1];
    assign sat_neg = big | q[V] | (q[V-1] & (|q[V-2:0]));
    assign negq    = ~q[V-1:0] + 1'b1;

    always_comb begin
        if (ctl_reg[NS-1].err) begin
            reading_o = '0;
            status_o  = STAT_COINCIDENT;
        end else if (neg && sat_neg) begin
            reading_o = {1'b1, {(V-1){1'b0}}};
            status_o  = STAT_SATURATED;
        end else if (neg) begin
            reading_o = negq;
            status_o  = STAT_OK;
        end else if (sat_pos) begin
            reading_o = {1'b0, {(V-1){1'b1}}};
            status_o  = STAT_SATURATED;
        end else begin
            reading_o = q[V-1:0];
            status_o  = STAT_OK;
        end
    end

    assign ctl_o = ctl_reg[NS-1];

endmodule

// ----- rtl/cal_checker.sv -----
// ----------------------------------------------------------------------------
// cal_checker
// Port-level checks on the result channel of calibrated_sensor_value.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cal_checker #(
    parameter int VALUE_BITS = cal_pkg::VALUE_BITS_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((VALUE_BITS+7)/8)*8-1:0]     m_axis_tdata,
    input logic [1:0]                          m_axis_tuser
);
    import cal_pkg::*;

    localparam logic [VALUE_BITS-1:0] MAX_RD = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] MIN_RD = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic [VALUE_BITS-1:0] rd;
    assign rd = m_axis_tdata[VALUE_BITS-1:0];

    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_axis_tvalid, "valid after reset")
    `ASSERT_CLK(a_hold, aclk, aresetn, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "transfer dropped")
    `ASSERT_CLK(a_coinc_zero, aclk, aresetn, (m_axis_tvalid && m_axis_tuser == STAT_COINCIDENT) |-> rd == '0, "coincident reading not zero")
    `ASSERT_CLK(a_sat_bound, aclk, aresetn, (m_axis_tvalid && m_axis_tuser == STAT_SATURATED) |-> (rd == MAX_RD || rd == MIN_RD), "saturated reading off bound")

endmodule

bind calibrated_sensor_value cal_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_cal_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/calibrated_sensor_value_tb.sv -----
// ----------------------------------------------------------------------------
// calibrated_sensor_value_tb
// Self-checking bench for the two/three-point calibration block. Directed
// rows, then random codes under several calibration sets, are pushed
// through the stream ports with random idle bursts on both sides. Every
// output transfer is compared with an exact rational model rounded to
// nearest, ties away from zero, with saturation and coincident-code flags.
// ----------------------------------------------------------------------------
module calibrated_sensor_value_tb;
    import cal_pkg::*;

    localparam int LATENCY = 42;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] reading;
        status_t            status;
    } cal_result_t;

    typedef struct {
        logic signed [15:0] code;
        bit                 known;
        logic signed [31:0] reading;
        status_t            status;
    } code_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [31:0] cfg_wdata;

    logic signed [15:0] cal_code [3];
    logic signed [31:0] cal_value [3];
    bit                 cal_quadratic;

    cal_result_t expected_readings[$];
    int  mismatches;
    int  idle_cycles;
    int  sink_hold;
    bit  calm_sink;

    calibrated_sensor_value DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic cal_result_t calibrate(logic signed [15:0] code);
        cal_result_t res;
        logic signed [127:0] num, den, nm, dm, q;
        logic signed [127:0] x, c1, c2, c3, v1, v2, v3;
        bit neg;
        x = code;
        c1 = cal_code[0]; c2 = cal_code[1]; c3 = cal_code[2];
        v1 = cal_value[0]; v2 = cal_value[1]; v3 = cal_value[2];
        res.reading = '0;
        res.status = STAT_OK;
        if (cal_quadratic) begin
            if (c1 == c2 || c1 == c3 || c2 == c3) begin
                res.status = STAT_COINCIDENT;
                return res;
            end
            num = v1 * (x - c2) * (x - c3) * (c2 - c3)
                - v2 * (x - c1) * (x - c3) * (c1 - c3)
                + v3 * (x - c1) * (x - c2) * (c1 - c2);
            den = (c1 - c2) * (c1 - c3) * (c2 - c3);
        end else begin
            if (c1 == c2) begin
                res.status = STAT_COINCIDENT;
                return res;
            end
            num = v2 * (x - c1) - v1 * (x - c2);
            den = c2 - c1;
        end
        neg = (num < 0) != (den < 0);
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        q = (2 * nm + dm) / (2 * dm);
        if (neg) begin
            if (q > 128'sd2147483648) begin
                q = 128'sd2147483648;
                res.status = STAT_SATURATED;
            end
            q = -q;
        end else if (q > 128'sd2147483647) begin
            q = 128'sd2147483647;
            res.status = STAT_SATURATED;
        end
        res.reading = q[31:0];
        return res;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_P1_CODE:   cal_code[0] = val[15:0];
            REG_P1_VALUE:  cal_value[0] = val;
            REG_P2_CODE:   cal_code[1] = val[15:0];
            REG_P2_VALUE:  cal_value[1] = val;
            REG_P3_CODE:   cal_code[2] = val[15:0];
            REG_P3_VALUE:  cal_value[2] = val;
            REG_USE_THIRD: cal_quadratic = val[0];
            default: ;
        endcase
    endtask

    task automatic load_points(logic [15:0] c1, logic [31:0] v1, logic [15:0] c2,
                               logic [31:0] v2, logic [15:0] c3, logic [31:0] v3,
                               bit quad);
        write_reg(REG_P1_CODE, {16'(signed'(c1))});
        write_reg(REG_P1_VALUE, v1);
        write_reg(REG_P2_CODE, {16'h0, c2});
        write_reg(REG_P2_VALUE, v2);
        write_reg(REG_P3_CODE, {{16{c3[15]}}, c3});
        write_reg(REG_P3_VALUE, v3);
        write_reg(REG_USE_THIRD, {31'd0, quad});
    endtask

    task automatic drain;
        wait (expected_readings.size() == 0);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic send_code(logic signed [15:0] code, bit gaps);
        if (gaps && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = code;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_readings.push_back(calibrate(code));
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic random_phase(int count, bit gaps);
        logic signed [15:0] code;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 5))
                0: code = cal_code[$urandom_range(0, 2)];
                1: code = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                2: code = cal_code[$urandom_range(0, 2)] + $signed(16'($urandom_range(0, 6)) - 16'sd3);
                default: code = 16'($urandom);
            endcase
            send_code(code, gaps);
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn || calm_sink) begin
            m_axis_tready <= 1'b1;
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            if (sink_hold == 1) m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            sink_hold <= $urandom_range(1, 15);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_readings.size() == 0) begin
                $error("reading: unexpected transfer, actual %0d",
                       $signed(m_axis_tdata));
                mismatches++;
            end else begin
                cal_result_t exp_r;
                exp_r = expected_readings.pop_front();
                if (m_axis_tdata !== exp_r.reading) begin
                    $error("reading: expected %0d actual %0d", exp_r.reading,
                           $signed(m_axis_tdata));
                    mismatches++;
                end
                if (m_axis_tuser !== exp_r.status) begin
                    $error("status: expected %0d actual %0d", exp_r.status,
                           m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[calibrated_sensor_value] ERROR");
            $finish;
        end
    end

    code_row_t directed_rows[] = '{
        '{16'sd0,     1'b1, 32'sd1792, STAT_OK},
        '{16'sd2720,  1'b1, 32'sd1024, STAT_OK},
        '{16'sh7fff,  1'b0, 32'sd0,    STAT_OK},
        '{16'sh8000,  1'b0, 32'sd0,    STAT_OK},
        '{16'sd1360,  1'b1, 32'sd1408, STAT_OK},
        '{-16'sd1,    1'b0, 32'sd0,    STAT_OK},
        '{16'sd1,     1'b0, 32'sd0,    STAT_OK},
        '{16'sh5555,  1'b0, 32'sd0,    STAT_OK},
        '{16'shaaaa,  1'b0, 32'sd0,    STAT_OK}
    };

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_P1_CODE;
        cfg_wdata = '0;
        m_axis_tready = 1'b1;
        calm_sink = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        sink_hold = 0;
        cal_code = '{16'sd0, 16'sd2720, 16'sd0};
        cal_value = '{32'sd1792, 32'sd1024, 32'sd0};
        cal_quadratic = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            cal_result_t model_r;
            model_r = calibrate(directed_rows[i].code);
            if (directed_rows[i].known && (model_r.reading !== directed_rows[i].reading ||
                model_r.status !== directed_rows[i].status)) begin
                $error("reading: table row %0d expected %0d model %0d", i,
                       directed_rows[i].reading, model_r.reading);
                mismatches++;
            end
            send_code(directed_rows[i].code, 1'b0);
        end
        drain();

        // coincident line codes, then saturating slope at the value extremes
        load_points(16'h0100, 32'h7fffffff, 16'h0100, 32'h80000000, 16'h0, 32'h0, 1'b0);
        send_code(16'sd0, 1'b0);
        expected_readings[$].status = STAT_COINCIDENT;
        drain();
        load_points(16'h0000, 32'h7fffffff, 16'h0001, 32'h80000000, 16'h8000, 32'h1, 1'b0);
        send_code(16'sh7fff, 1'b0);
        send_code(16'sh8000, 1'b0);
        send_code(16'sd0, 1'b0);
        random_phase(300, 1'b1);
        drain();

        load_points(16'h8000, 32'h00000300, 16'h0000, 32'h00000700, 16'h7fff, 32'h00000e00, 1'b1);
        send_code(16'sh8000, 1'b0);
        send_code(16'sh7fff, 1'b0);
        random_phase(400, 1'b1);
        drain();

        load_points(16'h1000, 32'h00000100, 16'h1000, 32'h00000200, 16'h2000, 32'h0, 1'b1);
        random_phase(20, 1'b1);
        drain();

        load_points(16'hffff, 32'h80000000, 16'h0000, 32'h7fffffff, 16'h0001, 32'h80000000, 1'b1);
        random_phase(300, 1'b1);
        drain();

        load_points(16'(signed'($urandom_range(0, 65535))), $urandom, 16'($urandom), $urandom,
                    16'($urandom), $urandom, 1'b1);
        random_phase(400, 1'b1);
        drain();

        load_points(16'hf000, $urandom, 16'h0c00, $urandom, 16'h0, 32'h0, 1'b0);
        random_phase(200, 1'b1);
        calm_sink = 1'b1;
        random_phase(200, 1'b0);

        wait (expected_readings.size() == 0);
        repeat (LATENCY + 4) @(negedge aclk);
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("[calibrated_sensor_value] OK");
        else
            $display("[calibrated_sensor_value] ERROR");
        $finish;
    end
endmodule
